[design/bdpc_pkg.sv]
// Package for the button debounce and press classifier.
// Holds register indexes, reset values, LED mode codes and shared types.
// No dependencies.
package bdpc_pkg;

    localparam int TIMER_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PRESS_MAX_MS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS = 2'd2;

    localparam logic [TIMER_W-1:0] DEBOUNCE_MS_RESET = 16'd15;
    localparam logic [TIMER_W-1:0] SHORT_PRESS_MAX_MS_RESET = 16'd1000;
    localparam logic [TIMER_W-1:0] LONG_PRESS_MS_RESET = 16'd3000;

    localparam logic [1:0] LED_OFF = 2'd0;
    localparam logic [1:0] LED_SLOW = 2'd1;
    localparam logic [1:0] LED_FAST = 2'd2;

    localparam logic LEVEL_PRESSED = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic [TIMER_W-1:0] debounce_ms;
        logic [TIMER_W-1:0] short_press_max_ms;
        logic [TIMER_W-1:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] led_mode;
        logic       long_press_event;
        logic       short_press_event;
        logic       release_event;
        logic       press_event;
        logic       stable_level;
    } result_t;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        sat_inc = (v == TIMER_MAX) ? v : v + TIMER_W'(1);
    endfunction

endpackage

[design/bdpc_core.sv]
// Debounce filter, press timer and LED mode stepper for one sample per step.
// Depends on bdpc_pkg.
module bdpc_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  logic            raw_level,
    input  bdpc_pkg::cfg_t  cfg,
    output bdpc_pkg::result_t result
);

    logic                         filtered_reg, filtered_next;
    logic                         accepted_reg, accepted_next;
    logic                         prev_accepted_reg, prev_accepted_next;
    logic                         db_active_reg, db_active_next;
    logic [bdpc_pkg::TIMER_W-1:0] db_elapsed_reg, db_elapsed_next;
    logic [bdpc_pkg::TIMER_W-1:0] hold_reg, hold_next;
    logic                         long_armed_reg, long_armed_next;
    logic [1:0]                   mode_reg, mode_next;

    always_comb begin
        filtered_next = filtered_reg;
        accepted_next = accepted_reg;
        db_active_next = db_active_reg;
        db_elapsed_next = db_elapsed_reg;
        long_armed_next = long_armed_reg;
        mode_next = mode_reg;
        hold_next = bdpc_pkg::sat_inc(hold_reg);
        result = '0;

        if (raw_level != filtered_reg) begin
            filtered_next = raw_level;
            db_active_next = 1'b1;
            db_elapsed_next = '0;
        end else if (db_active_reg) begin
            db_elapsed_next = bdpc_pkg::sat_inc(db_elapsed_reg);
        end
        if (db_active_next && (db_elapsed_next >= cfg.debounce_ms)) begin
            accepted_next = filtered_next;
            db_active_next = 1'b0;
        end

        if (accepted_next != prev_accepted_reg) begin
            if (accepted_next == bdpc_pkg::LEVEL_PRESSED) begin
                result.press_event = 1'b1;
                long_armed_next = 1'b1;
                hold_next = '0;
                mode_next = (mode_reg == bdpc_pkg::LED_SLOW) ? bdpc_pkg::LED_FAST
                                                             : bdpc_pkg::LED_SLOW;
            end else begin
                result.release_event = 1'b1;
                result.short_press_event = (hold_next <= cfg.short_press_max_ms);
                long_armed_next = 1'b0;
            end
        end
        prev_accepted_next = accepted_next;

        if (long_armed_next && (hold_next >= cfg.long_press_ms)) begin
            result.long_press_event = 1'b1;
            long_armed_next = 1'b0;
        end

        result.stable_level = accepted_next;
        result.led_mode = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filtered_reg <= bdpc_pkg::LEVEL_RELEASED;
            accepted_reg <= bdpc_pkg::LEVEL_RELEASED;
            prev_accepted_reg <= bdpc_pkg::LEVEL_RELEASED;
            db_active_reg <= 1'b0;
            db_elapsed_reg <= '0;
            hold_reg <= '0;
            long_armed_reg <= 1'b0;
            mode_reg <= bdpc_pkg::LED_OFF;
        end else if (step_en) begin
            filtered_reg <= filtered_next;
            accepted_reg <= accepted_next;
            prev_accepted_reg <= prev_accepted_next;
            db_active_reg <= db_active_next;
            db_elapsed_reg <= db_elapsed_next;
            hold_reg <= hold_next;
            long_armed_reg <= long_armed_next;
            mode_reg <= mode_next;
        end
    end

endmodule

[design/button_debounce_press_classifier.sv]
// Button debounce and press classifier, top level: input register, core,
// result register and configuration registers. Depends on bdpc_pkg, bdpc_core.
// One item is one millisecond pin sample; each accepted item yields exactly one
// result item via the input register, core and result register, and a new item
// is taken every clock while the result side keeps up. The input register and
// the result register form a two-stage path, so throughput is then one item per
// cycle, as the core steps its state once per item. Configuration writes are
// always ready; write only while no item is in flight. Register index 3 is ignored.
module button_debounce_press_classifier (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bdpc_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] raw_level, [7:1] zero
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] stable_level, [1] press_event, [2] release_event, [3] short_press_event,
    // [4] long_press_event, [6:5] led_mode, [7] zero
    output logic [bdpc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bdpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bdpc_pkg::TIMER_W-1:0]         cfg_data
);

    bdpc_pkg::cfg_t    cfg_reg;
    bdpc_pkg::result_t core_result;
    bdpc_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              in_level_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    bdpc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .raw_level (in_level_reg),
        .cfg       (cfg_reg),
        .result    (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.debounce_ms <= bdpc_pkg::DEBOUNCE_MS_RESET;
            cfg_reg.short_press_max_ms <= bdpc_pkg::SHORT_PRESS_MAX_MS_RESET;
            cfg_reg.long_press_ms <= bdpc_pkg::LONG_PRESS_MS_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    bdpc_pkg::REG_DEBOUNCE_MS:        cfg_reg.debounce_ms <= cfg_data;
                    bdpc_pkg::REG_SHORT_PRESS_MAX_MS: cfg_reg.short_press_max_ms <= cfg_data;
                    bdpc_pkg::REG_LONG_PRESS_MS:      cfg_reg.long_press_ms <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {1'b0, out_reg.led_mode, out_reg.long_press_event,
                      out_reg.short_press_event, out_reg.release_event,
                      out_reg.press_event, out_reg.stable_level};

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_press_classifier.
// A predictor of the debounce and press logic in this file checks every result item.
// Depends on bdpc_pkg and the RTL of the block.
module tb;

    localparam int TIMER_W = bdpc_pkg::TIMER_W;
    localparam logic [bdpc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int HOLD_LIMIT = 16'hFFFF;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [bdpc_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [bdpc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [bdpc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [TIMER_W-1:0]               cfg_data;

    button_debounce_press_classifier u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [TIMER_W-1:0] cfg_debounce;
    logic [TIMER_W-1:0] cfg_short_max;
    logic [TIMER_W-1:0] cfg_long;

    logic               flt_lvl;
    logic               acc_lvl;
    logic               prev_acc;
    logic               deb_run;
    logic [TIMER_W-1:0] deb_cnt;
    logic [TIMER_W-1:0] hold_cnt;
    logic               long_arm;
    logic [1:0]         led_now;

    bdpc_pkg::result_t classified_q[$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      rx_hold_cycles = 0;
    bit      idle_en = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic bdpc_pkg::result_t classify_sample(input logic raw);
        bdpc_pkg::result_t r;
        r = '0;
        if (hold_cnt != HOLD_LIMIT) hold_cnt++;
        if (raw != flt_lvl) begin
            flt_lvl = raw;
            deb_run = 1'b1;
            deb_cnt = '0;
        end else if (deb_run && deb_cnt != HOLD_LIMIT) begin
            deb_cnt++;
        end
        if (deb_run && deb_cnt >= cfg_debounce) begin
            acc_lvl = flt_lvl;
            deb_run = 1'b0;
        end
        if (acc_lvl != prev_acc) begin
            if (acc_lvl == bdpc_pkg::LEVEL_PRESSED) begin
                r.press_event = 1'b1;
                long_arm = 1'b1;
                hold_cnt = '0;
                led_now = (led_now == bdpc_pkg::LED_SLOW) ? bdpc_pkg::LED_FAST
                                                          : bdpc_pkg::LED_SLOW;
            end else begin
                r.release_event = 1'b1;
                r.short_press_event = (hold_cnt <= cfg_short_max);
                long_arm = 1'b0;
            end
            prev_acc = acc_lvl;
        end
        if (long_arm && hold_cnt >= cfg_long) begin
            r.long_press_event = 1'b1;
            long_arm = 1'b0;
        end
        r.stable_level = acc_lvl;
        r.led_mode = led_now;
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        bdpc_pkg::result_t want;
        bdpc_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = bdpc_pkg::result_t'(m_tdata[$bits(bdpc_pkg::result_t)-1:0]);
            if (classified_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = classified_q.pop_front();
                report_field("stable_level", int'(want.stable_level), int'(got.stable_level));
                report_field("press_event", int'(want.press_event), int'(got.press_event));
                report_field("release_event", int'(want.release_event),
                             int'(got.release_event));
                report_field("short_press_event", int'(want.short_press_event),
                             int'(got.short_press_event));
                report_field("long_press_event", int'(want.long_press_event),
                             int'(got.long_press_event));
                report_field("led_mode", int'(want.led_mode), int'(got.led_mode));
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold_cycles = 0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic raw);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(bdpc_pkg::IN_TDATA_W-1){1'b0}}, raw};
        do @(posedge aclk); while (!s_tready);
        classified_q.push_back(classify_sample(raw));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_sample(lvl);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (classified_q.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [bdpc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [TIMER_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bdpc_pkg::REG_DEBOUNCE_MS:        cfg_debounce = val;
            bdpc_pkg::REG_SHORT_PRESS_MAX_MS: cfg_short_max = val;
            bdpc_pkg::REG_LONG_PRESS_MS:      cfg_long = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_config(input logic [TIMER_W-1:0] deb, input logic [TIMER_W-1:0] short_max,
                                input logic [TIMER_W-1:0] long_ms);
        wait_drained();
        write_reg(REG_UNUSED, TIMER_W'($urandom));
        write_reg(bdpc_pkg::REG_DEBOUNCE_MS, deb);
        write_reg(bdpc_pkg::REG_SHORT_PRESS_MAX_MS, short_max);
        write_reg(bdpc_pkg::REG_LONG_PRESS_MS, long_ms);
        cfg_valid <= 1'b0;
    endtask

    // clean bounce-then-hold runs, hold near thresholds <= 200 (else 0..30), plus noise
    task automatic run_random_phase(input int n_items);
        int   stop_at;
        int   deb;
        int   target;
        int   run_len;
        logic lvl;
        stop_at = items_sent + n_items;
        lvl = bdpc_pkg::LEVEL_PRESSED;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8)) send_sample(1'($urandom));
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    send_run(~lvl, $urandom_range(1, 2));
                    send_run(lvl, $urandom_range(1, 2));
                end
                deb = (cfg_debounce > 64) ? $urandom_range(0, 64) : cfg_debounce;
                target = ($urandom_range(0, 1) == 0) ? cfg_short_max : cfg_long;
                if (target > 200) target = $urandom_range(0, 30);
                run_len = deb + target + $urandom_range(0, 4) - 1;
                send_run(lvl, (run_len < 1) ? 1 : run_len);
                lvl = ~lvl;
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_run(bdpc_pkg::LEVEL_PRESSED, 17);
        send_run(bdpc_pkg::LEVEL_RELEASED, 16);
    endtask

    task automatic test_directed_edges();
        apply_config('0, '0, '0);
        send_sample(bdpc_pkg::LEVEL_PRESSED);
        send_sample(bdpc_pkg::LEVEL_RELEASED);
        send_sample(bdpc_pkg::LEVEL_PRESSED);
        send_sample(bdpc_pkg::LEVEL_RELEASED);
        send_sample(bdpc_pkg::LEVEL_PRESSED);
        send_sample(bdpc_pkg::LEVEL_RELEASED);
        apply_config(16'd2, 16'hFFFF, 16'hFFFF);
        send_sample(bdpc_pkg::LEVEL_PRESSED);
        send_sample(bdpc_pkg::LEVEL_RELEASED);
        send_run(bdpc_pkg::LEVEL_PRESSED, 4);
        send_run(bdpc_pkg::LEVEL_RELEASED, 3);
        send_run(bdpc_pkg::LEVEL_PRESSED, 3);
        send_run(bdpc_pkg::LEVEL_RELEASED, 3);
    endtask

    task automatic test_backpressure();
        apply_config(16'd1, 16'd20, 16'd30);
        rx_hold_cycles = 200;
        run_random_phase(60);
        wait_drained();
        run_random_phase(30);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: apply_config('0, '0, '0);
                1: apply_config('0, 16'hFFFF, 16'hFFFF);
                2: apply_config(TIMER_W'($urandom), TIMER_W'($urandom), TIMER_W'($urandom));
                default: apply_config(TIMER_W'($urandom_range(0, 6)),
                                      TIMER_W'($urandom_range(0, 40)),
                                      TIMER_W'($urandom_range(0, 60)));
            endcase
            run_random_phase(250);
        end
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        apply_config(TIMER_W'($urandom_range(0, 4)), TIMER_W'($urandom_range(0, 30)),
                     TIMER_W'($urandom_range(0, 40)));
        run_random_phase(300);
    endtask

    initial begin
        int waited;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_debounce = bdpc_pkg::DEBOUNCE_MS_RESET;
        cfg_short_max = bdpc_pkg::SHORT_PRESS_MAX_MS_RESET;
        cfg_long = bdpc_pkg::LONG_PRESS_MS_RESET;
        flt_lvl = bdpc_pkg::LEVEL_RELEASED;
        acc_lvl = bdpc_pkg::LEVEL_RELEASED;
        prev_acc = bdpc_pkg::LEVEL_RELEASED;
        deb_run = 1'b0;
        deb_cnt = '0;
        hold_cnt = '0;
        long_arm = 1'b0;
        led_now = bdpc_pkg::LED_OFF;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_directed_edges();
        test_backpressure();
        test_random_phases();
        test_steady_stream();

        s_tvalid <= 1'b0;
        waited = 0;
        while (classified_q.size() != 0 && waited < 2000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (5) @(negedge aclk);
        if (classified_q.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, classified_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
